>>> src/fbdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fbdc_pkg;

  localparam int unsigned CLK_W             = 29;
  localparam int unsigned RATE_W            = 24;
  localparam int unsigned FRAC_W            = 3;
  localparam int unsigned ACH_W             = 26;
  localparam int unsigned INT_DIV_WIDTH_DEF = 16;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(12000000);

endpackage
`default_nettype wire

>>> src/fbdc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fbdc_req_if;
  logic                          valid;
  logic                          ready;
  logic [fbdc_pkg::RATE_W-1:0]   baud_rate;

  modport source (output valid, output baud_rate, input ready);
  modport sink   (input valid, input baud_rate, output ready);
endinterface

interface fbdc_rsp_if #(
  parameter int unsigned INT_W = fbdc_pkg::INT_DIV_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic                          oversample_8x;
  logic [INT_W-1:0]              divisor_int;
  logic [fbdc_pkg::FRAC_W-1:0]   divisor_frac;
  logic [fbdc_pkg::ACH_W-1:0]    achieved_rate;

  modport source (output valid, output ok, output oversample_8x, output divisor_int,
                  output divisor_frac, output achieved_rate, input ready);
  modport sink   (input valid, input ok, input oversample_8x, input divisor_int,
                  input divisor_frac, input achieved_rate, output ready);
endinterface
`default_nettype wire

>>> src/fbdc_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage, with several lanes side by side.
module fbdc_div_pipe #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned NUM_W  = 8,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [LANES-1:0][NUM_W-1:0]        in_num_i,
  input  wire logic [LANES-1:0][DEN_W-1:0]        in_den_i,
  input  wire logic [SIDE_W-1:0]                  in_side_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [LANES-1:0][NUM_W-1:0]        out_quo_o,
  output      logic [SIDE_W-1:0]                  out_side_o
);

  logic                          v_q    [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]   a_q    [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]   r_q    [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]   d_q    [NUM_W];
  logic [SIDE_W-1:0]             s_q    [NUM_W];

  logic                          pv     [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]   pa     [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]   pr     [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]   pd     [NUM_W];
  logic [SIDE_W-1:0]             ps     [NUM_W];
  logic                          rdy    [NUM_W+1];

  assign rdy[NUM_W] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [LANES-1:0][NUM_W-1:0] a_d;
    logic [LANES-1:0][DEN_W-1:0] r_d;

    if (k == 0) begin : g_first
      assign pv[k] = in_valid_i;
      assign pa[k] = in_num_i;
      assign pr[k] = '0;
      assign pd[k] = in_den_i;
      assign ps[k] = in_side_i;
    end else begin : g_next
      assign pv[k] = v_q[k-1];
      assign pa[k] = a_q[k-1];
      assign pr[k] = r_q[k-1];
      assign pd[k] = d_q[k-1];
      assign ps[k] = s_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_comb begin
      logic [DEN_W:0] r_ext;
      logic [DEN_W:0] diff;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        r_ext    = {pr[k][l], pa[k][l][NUM_W-1]};
        diff     = r_ext - {1'b0, pd[k][l]};
        ge       = (r_ext >= {1'b0, pd[k][l]});
        r_d[l]   = ge ? diff[DEN_W-1:0] : r_ext[DEN_W-1:0];
        a_d[l]   = {pa[k][l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= pv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        a_q[k] <= a_d;
        r_q[k] <= r_d;
        d_q[k] <= pd[k];
        s_q[k] <= ps[k];
      end
    end
  end

  assign out_valid_o = v_q[NUM_W-1];
  assign out_quo_o   = a_q[NUM_W-1];
  assign out_side_o  = s_q[NUM_W-1];

endmodule
`default_nettype wire

>>> src/fractional_baud_divisor_calc_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Order: preparation register, candidate divider, selection register, rate divider, output register.
// Throughput: one request per cycle while not stalled; each of the 59 divider stages resolves one quotient bit.
// Back-pressure ripples stage by stage, so bubbles are squeezed out while a result waits.
// Reset: asynchronous, active low; empties the pipeline and sets the clock to 12000000 Hz.
module fractional_baud_divisor_calc_unit #(
  parameter int unsigned INT_DIV_WIDTH = fbdc_pkg::INT_DIV_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fbdc_pkg::CLK_W-1:0]   cfg_wdata_i,
  fbdc_req_if.sink                          req_i,
  fbdc_rsp_if.source                        rsp_o
);

  // The first divider works out both candidate divisors at once: lane 0 gives the
  // 16x eighth-unit value (pclk + rate) / (2 * rate), lane 1 the 8x value
  // (pclk + rate / 2) / rate. Numerators need one bit above the clock width.
  localparam int unsigned NUM1_W = fbdc_pkg::CLK_W + 1;
  localparam int unsigned DEN1_W = fbdc_pkg::RATE_W + 1;
  localparam int unsigned CDF_W  = NUM1_W - fbdc_pkg::FRAC_W;
  // The second divider yields the achieved rate. Since the full divisor is always a
  // multiple of eight, (pclk * 8) / div reduces to pclk / (div / 8).
  localparam int unsigned NUM2_W = fbdc_pkg::CLK_W;
  localparam int unsigned DEN2_W = INT_DIV_WIDTH + fbdc_pkg::FRAC_W + 1;
  localparam int unsigned SIDE2_W = 2 + INT_DIV_WIDTH + fbdc_pkg::FRAC_W;

  logic [fbdc_pkg::CLK_W-1:0] pclk_q;

  // Configuration is to be written only while the pipeline is empty, a rule left to the user,
  // so the live value can feed both the preparation stage and the second divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pclk_q <= fbdc_pkg::CLK_RESET;
    end else if (cfg_we_i) begin
      pclk_q <= cfg_wdata_i;
    end
  end

  // Preparation stage: form numerators and denominators for the first divider.
  logic                          p_v_q;
  logic                          p_rdy;
  logic [1:0][NUM1_W-1:0]        p_num_q;
  logic [1:0][DEN1_W-1:0]        p_den_q;
  logic                          p_zero_q;
  logic                          d1_in_ready;

  assign p_rdy       = !p_v_q || d1_in_ready;
  assign req_i.ready = p_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (p_rdy) begin
      p_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy) begin
      p_num_q[0] <= {1'b0, pclk_q} + NUM1_W'(req_i.baud_rate);
      p_num_q[1] <= {1'b0, pclk_q} + NUM1_W'(req_i.baud_rate[fbdc_pkg::RATE_W-1:1]);
      p_den_q[0] <= {req_i.baud_rate, 1'b0};
      p_den_q[1] <= {1'b0, req_i.baud_rate};
      p_zero_q   <= (req_i.baud_rate == '0);
    end
  end

  logic                   d1_out_valid;
  logic                   d1_out_ready;
  logic [1:0][NUM1_W-1:0] d1_quo;
  logic                   d1_zero;

  fbdc_div_pipe #(
    .LANES  (2),
    .NUM_W  (NUM1_W),
    .DEN_W  (DEN1_W),
    .SIDE_W (1)
  ) u_div_cand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_v_q),
    .in_ready_o  (d1_in_ready),
    .in_num_i    (p_num_q),
    .in_den_i    (p_den_q),
    .in_side_i   (p_zero_q),
    .out_valid_o (d1_out_valid),
    .out_ready_i (d1_out_ready),
    .out_quo_o   (d1_quo),
    .out_side_o  (d1_zero)
  );

  // Selection stage: choose the oversampling mode, split and saturate the divisor,
  // and build the reduced divisor for the achieved-rate division.
  logic                          s_v_q;
  logic                          s_rdy;
  logic                          s_ok_q;
  logic                          s_over_q;
  logic [INT_DIV_WIDTH-1:0]      s_cd_q;
  logic [fbdc_pkg::FRAC_W-1:0]   s_fp_q;
  logic [DEN2_W-1:0]             s_den_q;
  logic                          d2_in_ready;

  logic                          sel_over;
  logic [NUM1_W-1:0]             sel_e;
  logic [CDF_W-1:0]              sel_cdf;
  logic                          sel_ok;
  logic                          sel_sat;
  logic [INT_DIV_WIDTH-1:0]      sel_cd;
  logic [fbdc_pkg::FRAC_W-1:0]   sel_fp;

  always_comb begin
    // A 16x value below eight means the integer part would be zero: fall back to 8x.
    sel_over = (d1_quo[0][NUM1_W-1:fbdc_pkg::FRAC_W] == '0);
    sel_e    = sel_over ? d1_quo[1] : d1_quo[0];
    sel_cdf  = sel_e[NUM1_W-1:fbdc_pkg::FRAC_W];
    sel_ok   = !d1_zero && (sel_cdf != '0);
    sel_sat  = (sel_cdf[CDF_W-1:INT_DIV_WIDTH] != '0);
    if (!sel_ok) begin
      sel_cd = '0;
      sel_fp = '0;
    end else if (sel_sat) begin
      sel_cd = '1;
      sel_fp = '0;
    end else begin
      sel_cd = sel_cdf[INT_DIV_WIDTH-1:0];
      sel_fp = sel_e[fbdc_pkg::FRAC_W-1:0];
    end
  end

  assign s_rdy        = !s_v_q || d2_in_ready;
  assign d1_out_ready = s_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (s_rdy) begin
      s_v_q <= d1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_rdy) begin
      s_ok_q   <= sel_ok;
      s_over_q <= sel_over;
      s_cd_q   <= sel_cd;
      s_fp_q   <= sel_fp;
      // 8x divides by the eighth-unit divisor, 16x by twice that.
      s_den_q  <= sel_over ? {1'b0, sel_cd, sel_fp} : {sel_cd, sel_fp, 1'b0};
    end
  end

  logic                   d2_out_valid;
  logic                   d2_out_ready;
  logic [0:0][NUM2_W-1:0] d2_quo;
  logic [SIDE2_W-1:0]     d2_side;

  fbdc_div_pipe #(
    .LANES  (1),
    .NUM_W  (NUM2_W),
    .DEN_W  (DEN2_W),
    .SIDE_W (SIDE2_W)
  ) u_div_rate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_v_q),
    .in_ready_o  (d2_in_ready),
    .in_num_i    (pclk_q),
    .in_den_i    (s_den_q),
    .in_side_i   ({s_ok_q, s_over_q, s_cd_q, s_fp_q}),
    .out_valid_o (d2_out_valid),
    .out_ready_i (d2_out_ready),
    .out_quo_o   (d2_quo),
    .out_side_o  (d2_side)
  );

  // Output register: a failed request reports zero in every field.
  logic                          o_v_q;
  logic                          o_rdy;
  logic                          o_ok_q;
  logic                          o_over_q;
  logic [INT_DIV_WIDTH-1:0]      o_cd_q;
  logic [fbdc_pkg::FRAC_W-1:0]   o_fp_q;
  logic [fbdc_pkg::ACH_W-1:0]    o_ach_q;
  logic                          d2_ok;

  assign d2_ok        = d2_side[SIDE2_W-1];
  assign o_rdy        = !o_v_q || rsp_o.ready;
  assign d2_out_ready = o_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_rdy) begin
      o_v_q <= d2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy) begin
      o_ok_q   <= d2_ok;
      o_over_q <= d2_ok && d2_side[SIDE2_W-2];
      o_cd_q   <= d2_side[fbdc_pkg::FRAC_W +: INT_DIV_WIDTH];
      o_fp_q   <= d2_side[fbdc_pkg::FRAC_W-1:0];
      o_ach_q  <= d2_ok ? d2_quo[0][fbdc_pkg::ACH_W-1:0] : '0;
    end
  end

  assign rsp_o.valid         = o_v_q;
  assign rsp_o.ok            = o_ok_q;
  assign rsp_o.oversample_8x = o_over_q;
  assign rsp_o.divisor_int   = o_cd_q;
  assign rsp_o.divisor_frac  = o_fp_q;
  assign rsp_o.achieved_rate = o_ach_q;

  // A failed result carries nothing but zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ok |-> rsp_o.divisor_int == '0 && rsp_o.divisor_frac == '0
                                 && rsp_o.achieved_rate == '0 && !rsp_o.oversample_8x)
    else $error("failed result has non-zero fields");

  // The 8x fallback is only taken when the divisor is below two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.oversample_8x |-> rsp_o.ok && rsp_o.divisor_int <= INT_DIV_WIDTH'(1))
    else $error("8x oversampling with a large divisor");

  // The input can only be held off once back-pressure has filled up to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> o_v_q && !rsp_o.ready)
    else $error("input stalled while the output stage can move");

endmodule
`default_nettype wire

>>> sim/fractional_baud_divisor_calc_unit_tb.sv
`timescale 1ns / 1ps
module fractional_baud_divisor_calc_unit_tb;

  localparam int unsigned CLK_W = fbdc_pkg::CLK_W;
  localparam int unsigned RATE_W = fbdc_pkg::RATE_W;
  localparam int unsigned FRAC_W = fbdc_pkg::FRAC_W;
  localparam int unsigned ACH_W = fbdc_pkg::ACH_W;
  localparam logic [CLK_W-1:0] CLK_RESET = fbdc_pkg::CLK_RESET;
  localparam int unsigned INT_W = fbdc_pkg::INT_DIV_WIDTH_DEF;
  localparam int unsigned LATENCY = 62;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_PHASE = 3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 62;
  localparam int unsigned HOLD_ITEMS = 120;

  // One expected response, held in the order that requests were transferred.
  typedef struct packed {
    logic             ok;
    logic             over8;
    logic [INT_W-1:0] div_int;
    logic [FRAC_W-1:0] div_frac;
    logic [ACH_W-1:0] ach_rate;
  } divisor_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CLK_W-1:0] cfg_wdata;

  fbdc_req_if req_bus ();
  fbdc_rsp_if #(.INT_W(INT_W)) rsp_bus ();

  fractional_baud_divisor_calc_unit #(.INT_DIV_WIDTH(INT_W)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus.sink),
    .rsp_o      (rsp_bus.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // The predictor's copy of the clock register.
  logic [CLK_W-1:0] pclk_model;
  logic [RATE_W-1:0] rate_queue[$];
  divisor_t divisor_queue[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned phase_num;
  int unsigned failures = 0;
  longint unsigned cycle_count = 0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_count = 0;

  // Works out the divisor for one rate with the present clock, in exact wide arithmetic.
  function automatic divisor_t calc_divisor(logic [RATE_W-1:0] rate, logic [CLK_W-1:0] pclk);
    divisor_t d;
    logic [63:0] eighths, cd, fp, scale, div;
    d = '0;
    if (rate == 0) return d;
    d.over8 = 1'b0;
    eighths = (64'(pclk) + 64'(rate)) / (64'(rate) * 2);
    if (eighths < 8) begin
      d.over8 = 1'b1;
      eighths = (64'(pclk) + 64'(rate >> 1)) / 64'(rate);
    end
    cd = eighths >> 3;
    fp = eighths & 64'h7;
    if (cd == 0) return '0;
    if (cd > ((64'd1 << INT_W) - 1)) begin
      cd = (64'd1 << INT_W) - 1;
      fp = 0;
    end
    scale = d.over8 ? 64'd8 : 64'd16;
    div = scale * ((cd << 3) + fp);
    d.ok = 1'b1;
    d.div_int = cd[INT_W-1:0];
    d.div_frac = fp[FRAC_W-1:0];
    d.ach_rate = ACH_W'((64'(pclk) << 3) / div);
    return d;
  endfunction

  // Driver: offers the next pending rate, holding it until the transfer happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.baud_rate <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        divisor_queue.push_back(calc_divisor(req_bus.baud_rate, pclk_model));
        void'(rate_queue.pop_front());
      end
      if (req_bus.valid && !req_bus.ready) begin
        // Keep offering the same item.
      end else if (rate_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_bus.valid <= 1'b1;
        req_bus.baud_rate <= rate_queue[0];
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Long hold-off on the response side, counted here once its phase has begun.
  always @(posedge clk_i) begin
    if (phase_num == HOLD_PHASE && !hold_done) begin
      if (hold_count < HOLD_CYCLES) begin
        hold_off <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  // Monitor: compares every response transfer with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (divisor_queue.size() == 0) begin
          $error("response with no request outstanding");
          failures++;
        end else begin
          divisor_t e;
          e = divisor_queue.pop_front();
          if (rsp_bus.ok !== e.ok) begin
            $error("ok: expected %0d, actual %0d", e.ok, rsp_bus.ok); failures++;
          end
          if (rsp_bus.oversample_8x !== e.over8) begin
            $error("oversample_8x: expected %0d, actual %0d", e.over8, rsp_bus.oversample_8x);
            failures++;
          end
          if (rsp_bus.divisor_int !== e.div_int) begin
            $error("divisor_int: expected %0d, actual %0d", e.div_int, rsp_bus.divisor_int);
            failures++;
          end
          if (rsp_bus.divisor_frac !== e.div_frac) begin
            $error("divisor_frac: expected %0d, actual %0d", e.div_frac, rsp_bus.divisor_frac);
            failures++;
          end
          if (rsp_bus.achieved_rate !== e.ach_rate) begin
            $error("achieved_rate: expected %0d, actual %0d", e.ach_rate,
                   rsp_bus.achieved_rate);
            failures++;
          end
        end
      end
      if (hold_off) begin
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on a free-running cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Waits until every queued rate has been transferred and every response has come back,
  // then lets the pipeline drain before the clock register may change.
  task automatic wait_idle();
    while (rate_queue.size() != 0 || req_bus.valid || divisor_queue.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Writes the clock register while the block is idle.
  task automatic write_pclk(logic [CLK_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    pclk_model = value;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random rates: drawn evenly from anywhere, up to 300000, up to 64, and the clock over 8 to 400.
  task automatic queue_random(int unsigned count);
    logic [RATE_W-1:0] r;
    repeat (count) begin
      case ($urandom_range(3))
        0: r = RATE_W'($urandom);
        1: r = RATE_W'($urandom_range(1, 300000));
        2: r = RATE_W'($urandom_range(0, 64));
        default: r = (pclk_model == 0) ? RATE_W'($urandom) :
                     RATE_W'(64'(pclk_model) / $urandom_range(8, 400));
      endcase
      rate_queue.push_back(r);
    end
  endtask

  initial begin
    logic [CLK_W-1:0] clocks[6];
    clocks = '{CLK_RESET, 29'h1FFFFFFF, 29'd0, 29'd48000000, 29'd1, 29'd3686400};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pclk_model = CLK_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_num = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, the 8x switch, saturation, too-low clock and zero rate.
    rate_queue.push_back('0);
    rate_queue.push_back(24'hFFFFFF);
    rate_queue.push_back(24'd1);
    rate_queue.push_back(24'd9600);
    rate_queue.push_back(24'd115200);
    rate_queue.push_back(24'd750000);
    rate_queue.push_back(24'd1000000);
    rate_queue.push_back(24'd1500000);
    rate_queue.push_back(24'd12000000);
    rate_queue.push_back(24'd6000000);
    rate_queue.push_back(24'd8000001);
    rate_queue.push_back(24'hAAAAAA);
    rate_queue.push_back(24'h555555);
    wait_idle();
    write_pclk(29'h1FFFFFFF);
    rate_queue.push_back(24'd1);
    rate_queue.push_back(24'd100);
    rate_queue.push_back(24'hFFFFFF);
    wait_idle();
    write_pclk(29'd0);
    rate_queue.push_back(24'd1);
    rate_queue.push_back(24'd0);
    wait_idle();

    // Random phases through the clock settings and idling patterns.
    for (int p = 0; p < 24; p++) begin
      phase_num = p;
      write_pclk(p < 6 ? clocks[p] : CLK_W'($urandom));
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // In the hold-off phase more items are offered than the pipeline can hold.
      queue_random(p == HOLD_PHASE ? HOLD_ITEMS : PHASE_ITEMS);
      wait_idle();
    end

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
